>>> hdl/dptm_pkg.sv
// Shared types, constants and a helper function of the drum pad trigger to MIDI block.
package dptm_pkg;

  // Sizes
  localparam int unsigned PAD_COUNT_DEF = 5;
  localparam int unsigned PADS_MAX      = 5;
  localparam int unsigned FORCE_W       = 10;
  localparam int unsigned LEVEL_W       = 7;
  localparam int unsigned TIME_W        = 32;
  localparam int unsigned PAD_W         = 3;
  localparam int unsigned NOTE_W        = 7;
  localparam int unsigned CHAN_W        = 5;
  localparam int unsigned WINDOW_W      = 8;
  localparam int unsigned HOLD_W        = 16;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 16;

  // Force to velocity mapping: 35 + (raw - 25) * 92 / 475, clamped to 127.
  // The constant division is a multiply by a rounded-up reciprocal of 92/475,
  // exact over the whole 10-bit raw range.
  localparam int unsigned RAW_FLOOR    = 25;
  localparam int unsigned LEVEL_MIN    = 35;
  localparam int unsigned LEVEL_MAX    = 127;
  localparam int unsigned RECIP_K      = 203093;
  localparam int unsigned RECIP_SHIFT  = 20;
  localparam int unsigned PROD_W       = 28;
  localparam int unsigned QUOT_W       = PROD_W - RECIP_SHIFT;

  // Configuration reset values
  localparam logic [LEVEL_W-1:0]  TRIGGER_RST = LEVEL_W'(40);
  localparam logic [WINDOW_W-1:0] WINDOW_RST  = WINDOW_W'(4);
  localparam logic [HOLD_W-1:0]   HOLD_RST    = HOLD_W'(50);
  localparam logic [FORCE_W-1:0]  BEND_RST    = FORCE_W'(400);
  localparam logic [CHAN_W-1:0]   CHANNEL_RST = CHAN_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TRIGGER_LEVEL  = 3'd0,
    REG_PEAK_WINDOW_MS = 3'd1,
    REG_HOLD_TIME_MS   = 3'd2,
    REG_BEND_THRESHOLD = 3'd3,
    REG_MIDI_CHANNEL   = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MSG_PITCH_BEND = 2'd0,
    MSG_NOTE_ON    = 2'd1,
    MSG_NOTE_OFF   = 2'd2
  } msg_kind_e;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_CAPTURE = 2'd1,
    PH_HOLD    = 2'd2
  } phase_e;

  typedef struct packed {
    logic [TIME_W-1:0]  now_ms;
    logic [FORCE_W-1:0] force_thumb;
    logic [FORCE_W-1:0] force_index;
    logic [FORCE_W-1:0] force_middle;
    logic [FORCE_W-1:0] force_ring;
    logic [FORCE_W-1:0] force_pinky;
    logic [FORCE_W-1:0] flex_sample;
  } in_item_t;

  typedef struct packed {
    msg_kind_e          message_kind;
    logic [PAD_W-1:0]   pad;
    logic [NOTE_W-1:0]  note_number;
    logic [LEVEL_W-1:0] velocity;
    logic               bend_up;
    logic [CHAN_W-1:0]  channel;
    logic               last;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic             load;
    logic             level;
    logic             update;
    logic             emit;
    logic [PAD_W-1:0] pad_idx;
  } dptm_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic pending;
    logic slot_free;
  } dptm_status_t;

  // Fixed note of each pad
  function automatic logic [NOTE_W-1:0] pad_note(input logic [PAD_W-1:0] pad);
    logic [NOTE_W-1:0] note;
    case (pad)
      3'd0:    note = NOTE_W'(24);
      3'd1:    note = NOTE_W'(46);
      3'd2:    note = NOTE_W'(40);
      3'd3:    note = NOTE_W'(38);
      3'd4:    note = NOTE_W'(51);
      default: note = '0;
    endcase
    return note;
  endfunction

endpackage

>>> hdl/dptm_ctrl.sv
// Controller state machine: sequences scan intake, per-pad evaluation and message emission.
module dptm_ctrl #(
  parameter int unsigned PAD_COUNT = dptm_pkg::PAD_COUNT_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  dptm_pkg::dptm_status_t status_i,
  output dptm_pkg::dptm_cmd_t    cmd_o
);
  import dptm_pkg::*;

  localparam int unsigned PADS  = (PAD_COUNT < PADS_MAX) ? PAD_COUNT : PADS_MAX;
  localparam int unsigned IDX_W = (PADS > 1) ? $clog2(PADS) : 1;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_LEVEL  = 4'b0010,
    S_UPDATE = 4'b0100,
    S_EMIT   = 4'b1000
  } state_e;

  state_e             state_q, state_d;
  logic [IDX_W-1:0]   pad_idx_q, pad_idx_d;

  // Next state and commands
  always_comb begin
    state_d       = state_q;
    pad_idx_d     = pad_idx_q;
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    cmd_o.pad_idx = PAD_W'(pad_idx_q);
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          pad_idx_d  = '0;
          state_d    = S_LEVEL;
        end
      end
      S_LEVEL: begin
        cmd_o.level = 1'b1;
        state_d     = S_UPDATE;
      end
      S_UPDATE: begin
        cmd_o.update = 1'b1;
        if (pad_idx_q == IDX_W'(PADS - 1)) begin
          state_d = S_EMIT;
        end else begin
          pad_idx_d = pad_idx_q + 1'b1;
          state_d   = S_LEVEL;
        end
      end
      S_EMIT: begin
        if (!status_i.pending) begin
          state_d = S_IDLE;
        end else if (status_i.slot_free) begin
          cmd_o.emit = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      pad_idx_q <= '0;
    end else begin
      state_q   <= state_d;
      pad_idx_q <= pad_idx_d;
    end
  end

  // Emission waits for room in the output register
  a_emit_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> status_i.slot_free)
    else $error("emit issued while output register is occupied");

  // A new scan always starts evaluation at the first pad
  a_accept_starts_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_LEVEL && pad_idx_q == '0)
    else $error("accepted scan did not start evaluation at pad zero");

  // Once nothing is pending the controller returns to idle
  a_emit_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EMIT && !status_i.pending |=> state_q == S_IDLE)
    else $error("controller stuck in emission with nothing pending");

endmodule

>>> hdl/dptm_datapath.sv
// Datapath: configuration registers, pad state, level mapping, event flags and output register.
module dptm_datapath #(
  parameter int unsigned PAD_COUNT = dptm_pkg::PAD_COUNT_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  dptm_pkg::in_item_t                   in_item_i,
  output dptm_pkg::out_item_t                  out_item_o,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [dptm_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [dptm_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  dptm_pkg::dptm_cmd_t                  cmd_i,
  output dptm_pkg::dptm_status_t               status_o
);
  import dptm_pkg::*;

  localparam int unsigned PADS  = (PAD_COUNT < PADS_MAX) ? PAD_COUNT : PADS_MAX;
  localparam int unsigned IDX_W = (PADS > 1) ? $clog2(PADS) : 1;

  // Configuration
  logic [LEVEL_W-1:0]  trigger_q;
  logic [WINDOW_W-1:0] window_q;
  logic [HOLD_W-1:0]   hold_q;
  logic [FORCE_W-1:0]  bend_thr_q;
  logic [CHAN_W-1:0]   channel_q;

  // Latched scan and pad state
  in_item_t            scan_q;
  phase_e              phase_q [PADS];
  logic [TIME_W-1:0]   start_q [PADS];
  logic [LEVEL_W-1:0]  peak_q  [PADS];
  logic [PROD_W-1:0]   prod_q, prod_d;
  logic [PADS-1:0]     endc_q, endc_d;
  logic [PADS-1:0]     rel_q, rel_d;
  logic                sub_q, sub_d;
  out_item_t           out_q, out_d;
  logic                out_valid_q, out_valid_d;

  logic [IDX_W-1:0]    upd_idx, emit_idx, rd_idx;
  logic [PADS-1:0]     upd_bit, emit_bit;
  logic [FORCE_W-1:0]  force_sel;
  logic [FORCE_W-1:0]  raw_diff;
  logic [QUOT_W-1:0]   quot;
  logic [QUOT_W:0]     lvl_sum;
  logic [LEVEL_W-1:0]  lvl;
  logic [TIME_W-1:0]   dt;
  logic                window_open, held_long;
  logic                trig_start, capture_end, release_now;
  logic [LEVEL_W-1:0]  peak_rd;
  logic                has_endc;

  // Lowest set flag
  function automatic logic [IDX_W-1:0] first_set(input logic [PADS-1:0] vec);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = PADS - 1; i >= 0; i--) begin
      if (vec[i]) begin
        idx = IDX_W'(i);
      end
    end
    return idx;
  endfunction

  assign cfg_ready_o = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trigger_q  <= TRIGGER_RST;
      window_q   <= WINDOW_RST;
      hold_q     <= HOLD_RST;
      bend_thr_q <= BEND_RST;
      channel_q  <= CHANNEL_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_TRIGGER_LEVEL:  trigger_q  <= cfg_data_i[LEVEL_W-1:0];
        REG_PEAK_WINDOW_MS: window_q   <= cfg_data_i[WINDOW_W-1:0];
        REG_HOLD_TIME_MS:   hold_q     <= cfg_data_i[HOLD_W-1:0];
        REG_BEND_THRESHOLD: bend_thr_q <= cfg_data_i[FORCE_W-1:0];
        REG_MIDI_CHANNEL:   channel_q  <= cfg_data_i[CHAN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Latch the scan item
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      scan_q <= in_item_i;
    end
  end

  // Level stage: select the pad's force, take off RAW_FLOOR and multiply by RECIP_K
  always_comb begin
    case (cmd_i.pad_idx)
      3'd0:    force_sel = scan_q.force_thumb;
      3'd1:    force_sel = scan_q.force_index;
      3'd2:    force_sel = scan_q.force_middle;
      3'd3:    force_sel = scan_q.force_ring;
      3'd4:    force_sel = scan_q.force_pinky;
      default: force_sel = '0;
    endcase
    raw_diff = force_sel - FORCE_W'(RAW_FLOOR);
    if (force_sel > FORCE_W'(RAW_FLOOR)) begin
      prod_d = PROD_W'(raw_diff) * PROD_W'(RECIP_K);
    end else begin
      prod_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.level) begin
      prod_q <= prod_d;
    end
  end

  // Update stage: finish the level, then test the pad's phase
  assign upd_idx = cmd_i.pad_idx[IDX_W-1:0];
  assign upd_bit = PADS'(1) << upd_idx;
  assign quot    = prod_q[PROD_W-1:RECIP_SHIFT];
  assign lvl_sum = (QUOT_W + 1)'(LEVEL_MIN) + {1'b0, quot};
  assign lvl     = (lvl_sum > (QUOT_W + 1)'(LEVEL_MAX)) ? LEVEL_W'(LEVEL_MAX)
                                                       : lvl_sum[LEVEL_W-1:0];

  assign has_endc = |endc_q;
  assign emit_idx = has_endc ? first_set(endc_q) : first_set(rel_q);
  assign emit_bit = PADS'(1) << emit_idx;
  assign rd_idx   = cmd_i.update ? upd_idx : emit_idx;
  assign peak_rd  = peak_q[rd_idx];

  assign dt          = scan_q.now_ms - start_q[upd_idx];
  assign window_open = dt < TIME_W'(window_q);
  assign held_long   = dt > TIME_W'(hold_q);

  assign trig_start  = cmd_i.update && phase_q[upd_idx] == PH_IDLE && lvl > trigger_q;
  assign capture_end = cmd_i.update && phase_q[upd_idx] == PH_CAPTURE && !window_open;
  assign release_now = cmd_i.update && phase_q[upd_idx] == PH_HOLD && held_long &&
                       lvl < trigger_q;

  // Advance pad state; a released pad keeps its peak for the note-off
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PADS; i++) begin
        phase_q[i] <= PH_IDLE;
        start_q[i] <= '0;
        peak_q[i]  <= '0;
      end
    end else if (cmd_i.update) begin
      if (trig_start) begin
        phase_q[upd_idx] <= PH_CAPTURE;
        peak_q[upd_idx]  <= lvl;
        start_q[upd_idx] <= scan_q.now_ms;
      end else if (capture_end) begin
        phase_q[upd_idx] <= PH_HOLD;
        start_q[upd_idx] <= scan_q.now_ms;
      end else if (release_now) begin
        phase_q[upd_idx] <= PH_IDLE;
      end else if (phase_q[upd_idx] == PH_CAPTURE && lvl > peak_rd) begin
        peak_q[upd_idx]  <= lvl;
      end
    end
  end

  // Event flags and message assembly
  always_comb begin
    endc_d      = endc_q;
    rel_d       = rel_q;
    sub_d       = sub_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.load) begin
      endc_d = '0;
      rel_d  = '0;
      sub_d  = 1'b0;
    end
    if (capture_end) begin
      endc_d = endc_q | upd_bit;
    end
    if (release_now) begin
      rel_d = rel_q | upd_bit;
    end
    if (cmd_i.emit) begin
      out_valid_d       = 1'b1;
      out_d.pad         = PAD_W'(emit_idx);
      out_d.channel     = channel_q;
      if (has_endc && !sub_q) begin
        out_d.message_kind = MSG_PITCH_BEND;
        out_d.note_number  = '0;
        out_d.velocity     = '0;
        out_d.bend_up      = scan_q.flex_sample >= bend_thr_q;
        out_d.last         = 1'b0;
        sub_d              = 1'b1;
      end else if (has_endc) begin
        out_d.message_kind = MSG_NOTE_ON;
        out_d.note_number  = pad_note(PAD_W'(emit_idx));
        out_d.velocity     = peak_rd;
        out_d.bend_up      = 1'b0;
        out_d.last         = ((endc_q & ~emit_bit) == '0) && (rel_q == '0);
        endc_d             = endc_q & ~emit_bit;
        sub_d              = 1'b0;
      end else begin
        out_d.message_kind = MSG_NOTE_OFF;
        out_d.note_number  = pad_note(PAD_W'(emit_idx));
        out_d.velocity     = peak_rd;
        out_d.bend_up      = 1'b0;
        out_d.last         = (rel_q & ~emit_bit) == '0;
        rel_d              = rel_q & ~emit_bit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      endc_q      <= '0;
      rel_q       <= '0;
      sub_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      endc_q      <= endc_d;
      rel_q       <= rel_d;
      sub_q       <= sub_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_item_o         = out_q;
  assign out_valid_o        = out_valid_q;
  assign status_o.pending   = (|endc_q) || (|rel_q);
  assign status_o.slot_free = !out_valid_q || out_ready_i;

  // The message flagged last leaves no event behind
  a_last_clears_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit && out_d.last |=> !status_o.pending)
    else $error("events still pending after the last message of a scan");

endmodule

>>> hdl/drum_pad_trigger_to_midi.sv
// Top level of the drum pad trigger to MIDI block: controller plus datapath.
//
// Usage:
//   in channel  (in_valid_i/in_ready_o, in_item_i): one scan per item, a
//     millisecond timestamp, five raw pad forces and one flex sample.
//   out channel (out_valid_o/out_ready_i, out_item_o): MIDI events, pitch
//     bend then note-on per finished capture in pad order, then note-offs;
//     the final event of a scan carries last. A scan may cause no event.
//   cfg channel (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i): register
//     writes, always ready; write only while the block is idle.
// Timing: a scan is evaluated one pad at a time over min(PAD_COUNT,5) pads, each
//   as a level multiply and then a state update; events then leave one per cycle
//   through a single output register while out_ready_i is high. A scan causes at
//   most two events per pad. The output register lets a new scan be accepted
//   while the last event still waits to be taken.
// Reset: all pads idle, registers at their reset values, no event pending.
// Stall: while out_ready_i is low the event stays on the port and emission
//   pauses; pad state is kept.
module drum_pad_trigger_to_midi #(
  parameter int unsigned PAD_COUNT = dptm_pkg::PAD_COUNT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  dptm_pkg::in_item_t              in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output dptm_pkg::out_item_t             out_item_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [dptm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [dptm_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import dptm_pkg::*;

  dptm_cmd_t    cmd;
  dptm_status_t status;

  // Sequence the scan
  dptm_ctrl #(
    .PAD_COUNT (PAD_COUNT)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Hold state and build events
  dptm_datapath #(
    .PAD_COUNT (PAD_COUNT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .out_item_o  (out_item_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

>>> test/tb_top.sv
// Self-checking testbench of the drum pad trigger to MIDI block.
`timescale 1ns / 1ps

module tb_top;
  import dptm_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned MAX_REPORTS   = 60;
  localparam realtime     RUN_LIMIT     = 10_000_000ns;

  // Fixed note of each pad, in pad order
  localparam logic [NOTE_W-1:0] PAD_NOTES [PADS_MAX] = '{
    NOTE_W'(24), NOTE_W'(46), NOTE_W'(40), NOTE_W'(38), NOTE_W'(51)
  };

  // Tracks pad state and the MIDI events each scan must cause
  class midi_event_tracker;
    phase_e              pad_state [PADS_MAX];
    logic [TIME_W-1:0]   mark_ms   [PADS_MAX];
    logic [LEVEL_W-1:0]  peak      [PADS_MAX];
    logic [LEVEL_W-1:0]  trig_lvl;
    logic [WINDOW_W-1:0] window_ms;
    logic [HOLD_W-1:0]   hold_ms;
    logic [FORCE_W-1:0]  bend_thr;
    logic [CHAN_W-1:0]   chan;
    out_item_t           pending_events [$];
    int unsigned         errors;

    function new();
      for (int p = 0; p < PADS_MAX; p++) begin
        pad_state[p] = PH_IDLE;
        mark_ms[p]   = '0;
        peak[p]      = '0;
      end
      trig_lvl  = TRIGGER_RST;
      window_ms = WINDOW_RST;
      hold_ms   = HOLD_RST;
      bend_thr  = BEND_RST;
      chan      = CHANNEL_RST;
      errors    = 0;
    endfunction

    task report(input string what);
      errors++;
      if (errors <= MAX_REPORTS) $display("ERROR at %0t: %s", $realtime, what);
    endtask

    function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_TRIGGER_LEVEL:  trig_lvl  = data[LEVEL_W-1:0];
        REG_PEAK_WINDOW_MS: window_ms = data[WINDOW_W-1:0];
        REG_HOLD_TIME_MS:   hold_ms   = data[HOLD_W-1:0];
        REG_BEND_THRESHOLD: bend_thr  = data[FORCE_W-1:0];
        REG_MIDI_CHANNEL:   chan      = data[CHAN_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [LEVEL_W-1:0] level_of(input logic [FORCE_W-1:0] raw);
      int unsigned v;
      if (raw <= FORCE_W'(RAW_FLOOR)) return LEVEL_W'(LEVEL_MIN);
      v = LEVEL_MIN + ((32'(raw) - RAW_FLOOR) * 92) / 475;
      return (v > LEVEL_MAX) ? LEVEL_W'(LEVEL_MAX) : LEVEL_W'(v);
    endfunction

    function void push_event(input msg_kind_e kind, input int unsigned p,
                             input logic [NOTE_W-1:0] note, input logic [LEVEL_W-1:0] vel,
                             input logic bend);
      out_item_t ev;
      ev.message_kind = kind;
      ev.pad          = PAD_W'(p);
      ev.note_number  = note;
      ev.velocity     = vel;
      ev.bend_up      = bend;
      ev.channel      = chan;
      ev.last         = 1'b0;
      pending_events.push_back(ev);
    endfunction

    // Advance pad state by one scan and queue the events it causes
    function void note_scan(input in_item_t s);
      logic [LEVEL_W-1:0] lvl [PADS_MAX];
      logic [TIME_W-1:0]  age;
      logic               bend;
      int unsigned        before_cnt;
      before_cnt = pending_events.size();
      bend   = (s.flex_sample >= bend_thr);
      lvl[0] = level_of(s.force_thumb);
      lvl[1] = level_of(s.force_index);
      lvl[2] = level_of(s.force_middle);
      lvl[3] = level_of(s.force_ring);
      lvl[4] = level_of(s.force_pinky);
      // Captures: start, gather peak, or finish with bend then note-on
      for (int p = 0; p < PADS_MAX; p++) begin
        age = s.now_ms - mark_ms[p];
        if (pad_state[p] == PH_IDLE) begin
          if (lvl[p] > trig_lvl) begin
            pad_state[p] = PH_CAPTURE;
            peak[p]      = lvl[p];
            mark_ms[p]   = s.now_ms;
          end
        end else if (pad_state[p] == PH_CAPTURE) begin
          if (age < TIME_W'(window_ms)) begin
            if (lvl[p] > peak[p]) peak[p] = lvl[p];
          end else begin
            push_event(MSG_PITCH_BEND, p, '0, '0, bend);
            push_event(MSG_NOTE_ON, p, PAD_NOTES[p], peak[p], 1'b0);
            pad_state[p] = PH_HOLD;
            mark_ms[p]   = s.now_ms;
          end
        end
      end
      // Releases come after all captures of the scan
      for (int p = 0; p < PADS_MAX; p++) begin
        age = s.now_ms - mark_ms[p];
        if (pad_state[p] == PH_HOLD && age > TIME_W'(hold_ms) && lvl[p] < trig_lvl) begin
          push_event(MSG_NOTE_OFF, p, PAD_NOTES[p], peak[p], 1'b0);
          pad_state[p] = PH_IDLE;
          peak[p]      = '0;
          mark_ms[p]   = '0;
        end
      end
      if (pending_events.size() > before_cnt)
        pending_events[pending_events.size()-1].last = 1'b1;
    endfunction

    task compare_field(input string name, input int unsigned got, input int unsigned want);
      if (got != want) report($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    // Match one emitted event against the oldest expected one
    task check_event(input out_item_t got);
      out_item_t want;
      if (pending_events.size() == 0) begin
        report($sformatf("unexpected event kind %0d pad %0d", got.message_kind, got.pad));
      end else begin
        want = pending_events.pop_front();
        compare_field("message_kind", got.message_kind, want.message_kind);
        compare_field("pad", got.pad, want.pad);
        compare_field("note_number", got.note_number, want.note_number);
        compare_field("velocity", got.velocity, want.velocity);
        compare_field("bend_up", got.bend_up, want.bend_up);
        compare_field("channel", got.channel, want.channel);
        compare_field("last", got.last, want.last);
      end
    endtask

    function int unsigned pending();
      return pending_events.size();
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_item   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_item;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  midi_event_tracker tracker = new();
  int unsigned       send_run  = 0;
  int unsigned       recv_run  = 0;
  logic [TIME_W-1:0] scan_ms   = '0;
  bit                pressed [PADS_MAX];

  drum_pad_trigger_to_midi dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #6ns clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  // Draw a random wait, with occasional stretches of no waiting
  function automatic int unsigned draw_wait(inout int unsigned run);
    if (run != 0) begin
      run--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) run = $urandom_range(5, 30);
    return $urandom_range(0, 16);
  endfunction

  function automatic in_item_t make_scan(input logic [TIME_W-1:0] t,
                                         input logic [FORCE_W-1:0] f0, f1, f2, f3, f4,
                                         input logic [FORCE_W-1:0] flex);
    in_item_t s;
    s.now_ms       = t;
    s.force_thumb  = f0;
    s.force_index  = f1;
    s.force_middle = f2;
    s.force_ring   = f3;
    s.force_pinky  = f4;
    s.flex_sample  = flex;
    return s;
  endfunction

  // Offer one scan, hold it until accepted; drop valid only before a gap
  task automatic send_scan(input in_item_t s, input bit phase_end);
    int unsigned gap;
    gap = draw_wait(send_run);
    if (phase_end && gap == 0) gap = 1;
    in_valid <= 1'b1;
    in_item  <= s;
    do @(posedge clk); while (!in_ready);
    tracker.note_scan(s);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    tracker.write_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait for all events, then let a scan without events run out
  task automatic wait_idle();
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Reprogram the block, then play random finger presses on the pads
  task automatic run_phase(input logic [LEVEL_W-1:0] trig, input logic [WINDOW_W-1:0] win,
                           input logic [HOLD_W-1:0] hold, input logic [FORCE_W-1:0] thr,
                           input logic [CHAN_W-1:0] ch, input int unsigned step_max,
                           input int unsigned count);
    logic [FORCE_W-1:0] f [PADS_MAX];
    int unsigned        r;
    wait_idle();
    cfg_write(REG_MIDI_CHANNEL, {11'($urandom), ch});
    cfg_write(REG_TRIGGER_LEVEL, {9'($urandom), trig});
    cfg_write(CFG_IDX_W'($urandom_range(5, 7)), 16'($urandom));
    cfg_write(REG_PEAK_WINDOW_MS, {8'($urandom), win});
    cfg_write(REG_BEND_THRESHOLD, {6'($urandom), thr});
    cfg_write(REG_HOLD_TIME_MS, hold);
    for (int unsigned k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 3) scan_ms = scan_ms + $urandom;
      else if (r < 10) scan_ms = scan_ms + $urandom_range(0, 70000);
      else scan_ms = scan_ms + $urandom_range(0, step_max);
      for (int p = 0; p < PADS_MAX; p++) begin
        if ($urandom_range(0, 5) == 0) pressed[p] = !pressed[p];
        if ($urandom_range(0, 9) == 0) f[p] = FORCE_W'($urandom_range(0, 1023));
        else if (pressed[p]) f[p] = FORCE_W'($urandom_range(60, 1023));
        else f[p] = FORCE_W'($urandom_range(0, 55));
      end
      send_scan(make_scan(scan_ms, f[0], f[1], f[2], f[3], f[4],
                          FORCE_W'($urandom_range(0, 1023))), k == count - 1);
    end
  endtask

  // Take events with random stalls and check each one
  initial begin
    int unsigned stall;
    wait (rst_n);
    forever begin
      stall = draw_wait(recv_run);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      tracker.check_event(out_item);
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed scans at reset settings: level edges, window end, release rules
    send_scan(make_scan(32'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0), 0);
    send_scan(make_scan(32'd1, 10'd1023, 10'd25, 10'd26, 10'd500, 10'd1023, 10'd1023), 0);
    send_scan(make_scan(32'd2, 10'd300, 10'd0, 10'd1023, 10'd1023, 10'd0, 10'd0), 0);
    send_scan(make_scan(32'd5, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd400), 0);
    send_scan(make_scan(32'd6, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd399), 0);
    send_scan(make_scan(32'd55, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0), 0);
    send_scan(make_scan(32'd56, 10'd1023, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0), 0);
    send_scan(make_scan(32'd57, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0), 0);
    // Levels just below, at and just above the trigger level
    send_scan(make_scan(32'd58, 10'd51, 10'd56, 10'd50, 10'd0, 10'd0, 10'd0), 0);
    // Time wraps around zero during a capture and a hold
    send_scan(make_scan(32'hFFFF_FFF0, 10'd1023, 10'd0, 10'd0, 10'd0, 10'd0, 10'd512), 0);
    send_scan(make_scan(32'hFFFF_FFF3, 10'd600, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0), 0);
    send_scan(make_scan(32'h0000_0000, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd1023), 0);
    send_scan(make_scan(32'h0000_0040, 10'd50, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0), 0);
    // All pads at once: full capture burst, then all releases
    send_scan(make_scan(32'h0000_0100, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023,
                        10'd1023), 0);
    send_scan(make_scan(32'h0000_0101, 10'd700, 10'd800, 10'd900, 10'd600, 10'd400, 10'd0), 0);
    send_scan(make_scan(32'h0000_0104, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd1023), 0);
    send_scan(make_scan(32'h0000_0200, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0), 0);
    send_scan(make_scan(32'hFFFF_FFFF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF,
                        10'h3FF), 1);

    // Random phases: reset-like, low extremes, high extremes, zero window, then random
    scan_ms = 32'd1000;
    run_phase(7'd40, 8'd4, 16'd50, 10'd400, 5'd1, 12, 44);
    run_phase(7'd35, 8'd1, 16'd1, 10'd0, 5'd16, 4, 44);
    run_phase(7'd127, 8'd255, 16'd65535, 10'd1023, 5'd31, 300, 44);
    run_phase(7'd0, 8'd0, 16'd0, 10'd1023, 5'd0, 3, 44);
    run_phase(7'($urandom_range(35, 110)), 8'($urandom_range(0, 20)),
              16'($urandom_range(0, 300)), 10'($urandom), 5'($urandom_range(1, 16)),
              $urandom_range(1, 30), 44);
    scan_ms = 32'hFFFF_FF00;
    run_phase(7'($urandom_range(35, 110)), 8'($urandom_range(0, 20)),
              16'($urandom_range(0, 300)), 10'($urandom), 5'($urandom_range(1, 16)),
              $urandom_range(1, 30), 44);
    run_phase(7'($urandom_range(35, 110)), 8'($urandom_range(0, 20)),
              16'($urandom_range(0, 300)), 10'($urandom), 5'($urandom_range(1, 16)),
              $urandom_range(1, 30), 44);
    run_phase(7'($urandom_range(35, 127)), 8'($urandom_range(0, 255)),
              16'($urandom), 10'($urandom), 5'($urandom_range(1, 16)),
              $urandom_range(1, 30), 44);

    // Drain the remaining events, then let the block settle
    wait_idle();
    if (tracker.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
